/* hdl/assert_macros.svh */
// Assertion helpers shared by the codec modules.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define XEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define XEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/xec_pkg.sv */
// Types, codes and entity tables of the XML entity codec.
// No dependencies.
package xec_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int CFG_AW = 2;

  localparam logic [15:0] LIMIT_RESET = 16'd256;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_LONG    = 2'd2;
  localparam logic [1:0] ERR_CUT     = 2'd3;

  localparam logic [2:0] ENT_LT   = 3'd0;
  localparam logic [2:0] ENT_GT   = 3'd1;
  localparam logic [2:0] ENT_AMP  = 3'd2;
  localparam logic [2:0] ENT_APOS = 3'd3;
  localparam logic [2:0] ENT_QUOT = 3'd4;
  localparam int NUM_ENT = 5;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       end_of_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       value_done;
    logic [1:0] error;
  } out_item_t;

  // one queued job: a single result, or an entity to spell out
  typedef struct packed {
    logic       expand;
    logic [2:0] sel;
    logic [7:0] data;
    logic       eov;
    logic [1:0] err;
  } job_t;

  function automatic logic [7:0] ent_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      ENT_LT:   c = 8'h3C;
      ENT_GT:   c = 8'h3E;
      ENT_AMP:  c = 8'h26;
      ENT_APOS: c = 8'h27;
      ENT_QUOT: c = 8'h22;
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

  // length of the name after '&', including ';'
  function automatic logic [2:0] name_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      ENT_LT, ENT_GT:     n = 3'd3;
      ENT_AMP:            n = 3'd4;
      ENT_APOS, ENT_QUOT: n = 3'd5;
      default:            n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] i);
    logic [39:0] s;
    logic [7:0]  c;
    unique case (k)
      ENT_LT:   s = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C};
      ENT_GT:   s = {8'h00, 8'h00, 8'h3B, 8'h74, 8'h67};
      ENT_AMP:  s = {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61};
      ENT_APOS: s = {8'h3B, 8'h73, 8'h6F, 8'h70, 8'h61};
      ENT_QUOT: s = {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71};
      default:  s = '0;
    endcase
    unique case (i)
      3'd0:    c = s[7:0];
      3'd1:    c = s[15:8];
      3'd2:    c = s[23:16];
      3'd3:    c = s[31:24];
      3'd4:    c = s[39:32];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // encoded text: '&' then the name
  function automatic logic [2:0] ent_len(input logic [2:0] k);
    return name_len(k) + 3'd1;
  endfunction

  function automatic logic [7:0] ent_text(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0] c;
    if (pos == 3'd0) begin
      c = 8'h26;
    end else begin
      c = name_char(k, pos - 3'd1);
    end
    return c;
  endfunction

endpackage

/* hdl/xec_front.sv */
// Front end: accepts input beats, runs the decode state and classifies each
// byte into a job for the queue. Depends on xec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module xec_front import xec_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    item,
  input  logic [15:0] value_limit,
  output logic        job_valid,
  output job_t        job
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [COUNT_WIDTH-1:0] byte_cnt_r, byte_cnt_nxt, cnt_inc;
  logic                   in_ent_r, in_ent_nxt;
  logic                   dropping_r, dropping_nxt;
  logic [2:0]             ent_cnt_r, ent_cnt_nxt;
  logic [NUM_ENT-1:0]     cand_r, cand_nxt, cand_new, done_vec;

  logic       enc_hit;
  logic [2:0] enc_sel, done_sel;
  logic       b_is_amp;
  logic [7:0] b;
  logic       eov;

  assign b        = item.data_byte;
  assign eov      = item.end_of_value;
  assign b_is_amp = (b == 8'h26);
  assign cnt_inc  = (&byte_cnt_r) ? byte_cnt_r : byte_cnt_r + 1'b1;

  always_comb begin
    enc_hit = 1'b0;
    enc_sel = ENT_LT;
    for (int k = 0; k < NUM_ENT; k++) begin
      if (b == ent_char(3'(k))) begin
        enc_hit = 1'b1;
        enc_sel = 3'(k);
      end
    end
  end

  // surviving name candidates after this byte, and which one it completes
  always_comb begin
    done_sel = ENT_LT;
    for (int k = 0; k < NUM_ENT; k++) begin
      cand_new[k] = cand_r[k] && (ent_cnt_r < name_len(3'(k))) &&
                    (b == name_char(3'(k), ent_cnt_r));
      done_vec[k] = cand_new[k] && ((ent_cnt_r + 3'd1) == name_len(3'(k)));
      if (done_vec[k]) begin
        done_sel = 3'(k);
      end
    end
  end

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    in_ent_nxt   = in_ent_r;
    dropping_nxt = dropping_r;
    ent_cnt_nxt  = ent_cnt_r;
    cand_nxt     = cand_r;
    job_valid    = 1'b0;
    job.expand   = 1'b0;
    job.sel      = ENT_LT;
    job.data     = b;
    job.eov      = eov;
    job.err      = ERR_NONE;

    if (item.func == FUNC_ENCODE) begin
      job_valid  = 1'b1;
      job.expand = enc_hit;
      job.sel    = enc_sel;
    end else begin
      byte_cnt_nxt = cnt_inc;
      priority if (dropping_r) begin
        job_valid = 1'b0;
      end else if (CMP_W'(cnt_inc) >= CMP_W'(value_limit)) begin
        job_valid = 1'b1;
        job.err   = ERR_LONG;
      end else if (!in_ent_r) begin
        if (b_is_amp) begin
          if (eov) begin
            job_valid = 1'b1;
            job.err   = ERR_CUT;
          end else begin
            in_ent_nxt  = 1'b1;
            ent_cnt_nxt = 3'd0;
            cand_nxt    = '1;
          end
        end else begin
          job_valid = 1'b1;
        end
      end else if (cand_new == '0) begin
        job_valid = 1'b1;
        job.err   = ERR_UNKNOWN;
      end else if (done_vec != '0) begin
        job_valid  = 1'b1;
        job.data   = ent_char(done_sel);
        in_ent_nxt = 1'b0;
      end else if (eov) begin
        job_valid = 1'b1;
        job.err   = ERR_CUT;
      end else begin
        ent_cnt_nxt = ent_cnt_r + 3'd1;
        cand_nxt    = cand_new;
      end

      if (job_valid && job.err != ERR_NONE) begin
        dropping_nxt = 1'b1;
        in_ent_nxt   = 1'b0;
      end
      // end of value wipes all decode state
      if (eov) begin
        byte_cnt_nxt = '0;
        in_ent_nxt   = 1'b0;
        dropping_nxt = 1'b0;
      end
      if (!in_ent_nxt) begin
        ent_cnt_nxt = 3'd0;
      end
    end
    if (!accept) begin
      job_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      in_ent_r   <= 1'b0;
      dropping_r <= 1'b0;
      ent_cnt_r  <= 3'd0;
      cand_r     <= '0;
    end else if (accept) begin
      byte_cnt_r <= byte_cnt_nxt;
      in_ent_r   <= in_ent_nxt;
      dropping_r <= dropping_nxt;
      ent_cnt_r  <= ent_cnt_nxt;
      cand_r     <= cand_nxt;
    end
  end

  `XEC_ASSERT_NOW(a_drop_no_entity, dropping_r, !in_ent_r)
  `XEC_ASSERT_NOW(a_entity_has_cand, in_ent_r, cand_r != '0 && ent_cnt_r < 3'd5)

endmodule

/* hdl/xec_fifo.sv */
// Short job queue between front and back end.
// Depends on xec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module xec_fifo import xec_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `XEC_ASSERT_NOW(a_fifo_bound, 1'b1, cnt_r <= (QAW+1)'(QDEPTH))
  `XEC_ASSERT_NOW(a_fifo_ptrs, cnt_r == '0 || cnt_r == (QAW+1)'(QDEPTH), wr_ptr_r == rd_ptr_r)

endmodule

/* hdl/xec_back.sv */
// Back end: spells out queued jobs into the output register, one beat
// per cycle unless stalled. Depends on xec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module xec_back import xec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      head,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic [2:0] pos_r, pos_nxt;
  logic       ovalid_r, ovalid_nxt;
  out_item_t  out_r, res;
  logic       load, last;

  assign last = head.expand ? (pos_r == ent_len(head.sel) - 3'd1) : 1'b1;
  assign load = !q_empty && (!ovalid_r || pop);
  assign q_pop = load && last;

  always_comb begin
    res.last_of_run = last;
    res.value_done  = last && head.eov;
    res.error       = head.err;
    if (head.err != ERR_NONE) begin
      res.out_byte = 8'h00;
    end else if (head.expand) begin
      res.out_byte = ent_text(head.sel, pos_r);
    end else begin
      res.out_byte = head.data;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = last ? 3'd0 : pos_r + 3'd1;
    end
    ovalid_nxt = load || (ovalid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 3'd0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign empty    = !ovalid_r;
  assign out_item = out_r;

  `XEC_ASSERT_NOW(a_pos_in_range, !q_empty && head.expand, pos_r < ent_len(head.sel))
  `XEC_ASSERT_NEXT(a_pos_restart, q_pop, pos_r == 3'd0)

endmodule

/* hdl/xml_entity_codec.sv */
// XML entity codec, top level: config register, front end, job queue, back end.
// Depends on xec_pkg, xec_front, xec_fifo, xec_back.
//
// Input channel: in_data (func, data_byte, end_of_value) is taken on a clock
// edge with push high and full low. func 0 escapes the byte, func 1 unescapes.
// Result channel: out_data holds the oldest result while empty is low; it is
// taken on an edge with pop high. Each result carries out_byte, last_of_run,
// value_done and error.
// Config: APB-style port, one register value_limit at address 0 (reset 256).
// Throughput: one input beat per cycle, while full is low, for plain bytes and
// decode traffic; an escaped character spells out 4 to 6 result beats, one per
// cycle unless stalled; the back end sets the rate at the entity text length.
// A result passes through the job queue and the output register. A four-entry
// job queue decouples the sides; full rises when it fills, so a stalled
// receiver backs up into the input after the queue and output register fill.
// Entity bytes before the last, and dropped bytes, produce no result.
// Reset (synchronous, rst_n low) empties the queue, clears decode state and
// sets value_limit back to 256.
module xml_entity_codec import xec_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_item_t          in_data,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] limit_r;
  logic        accept, job_valid, q_full, q_empty, q_pop;
  job_t        job, head;

  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? {16'h0000, limit_r} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      limit_r <= pwdata[15:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  xec_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_data),
    .value_limit (limit_r),
    .job_valid   (job_valid),
    .job         (job)
  );

  xec_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_valid),
    .wr_job (job),
    .rd_en  (q_pop),
    .rd_job (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  xec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_data)
  );

endmodule

/* tb/xml_entity_codec_test.sv */
// Self-checking testbench for xml_entity_codec: escape/unescape byte streams,
// value_limit register over APB, random stalls on both queue sides.
// Depends on xec_pkg and the xml_entity_codec RTL.
module xml_entity_codec_test import xec_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 1000;  // cycles with no beat accepted anywhere
  localparam int DRAIN_CYCLES = 8;     // results trail their input through the queue and output register
  localparam int HOLD_CYCLES  = 80;
  localparam logic [CFG_AW-1:0] ADDR_VALUE_LIMIT = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  in_item_t          in_data = '0;
  logic              empty;
  logic              pop = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  xml_entity_codec i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // stimulus and expectations
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int in_gap_max = 13;
  int out_gap_max = 13;
  int in_wait = 0;
  int out_wait = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit out_hold_req = 1'b0;
  int out_hold_left = 0;

  int items_queued = 0;
  int beats_in = 0;
  int results_checked = 0;
  int error_results = 0;
  int limit_writes = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  // codec state as the predictor sees it
  logic [15:0] limit_now = LIMIT_RESET;
  logic [39:0] name_buf = '0;
  logic [2:0]  name_cnt = '0;
  logic        in_name = 1'b0;
  logic [15:0] value_bytes = '0;
  logic        dropping = 1'b0;

  // entity name as it follows '&', ';' included
  function automatic string ent_name(input logic [2:0] k);
    case (k)
      ENT_LT:   return "lt;";
      ENT_GT:   return "gt;";
      ENT_AMP:  return "amp;";
      ENT_APOS: return "apos;";
      default:  return "quot;";
    endcase
  endfunction

  function automatic logic [7:0] ent_glyph(input logic [2:0] k);
    case (k)
      ENT_LT:   return "<";
      ENT_GT:   return ">";
      ENT_AMP:  return "&";
      ENT_APOS: return "'";
      default:  return "\"";
    endcase
  endfunction

  task automatic emit(input logic [7:0] b, input logic last, input logic done,
                      input logic [1:0] err);
    out_item_t r;
    r.out_byte    = b;
    r.last_of_run = last;
    r.value_done  = done;
    r.error       = err;
    expected_results.push_back(r);
  endtask

  task automatic clear_value();
    name_buf    = '0;
    name_cnt    = '0;
    in_name     = 1'b0;
    value_bytes = '0;
    dropping    = 1'b0;
  endtask

  task automatic flag_error(input logic [1:0] code, input logic eov);
    emit(8'h00, 1'b1, eov, code);
    if (eov) begin
      clear_value();
    end else begin
      dropping = 1'b1;
      in_name  = 1'b0;
      name_buf = '0;
      name_cnt = '0;
    end
  endtask

  task automatic predict_codec_beat(input in_item_t it);
    logic [7:0] b;
    logic       eov;
    string      nm;
    int         hit;
    int         n;
    int         done_k;
    bit         prefix_ok;
    bit         ok;
    b = it.data_byte;
    eov = it.end_of_value;
    hit = -1;
    done_k = -1;
    prefix_ok = 1'b0;
    if (it.func == FUNC_ENCODE) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        if (b == ent_glyph(k[2:0])) hit = k;
      end
      if (hit < 0) begin
        emit(b, 1'b1, eov, ERR_NONE);
      end else begin
        nm = ent_name(hit[2:0]);
        emit("&", 1'b0, 1'b0, ERR_NONE);
        for (int i = 0; i < nm.len(); i++) begin
          emit(nm[i], i == nm.len() - 1, (i == nm.len() - 1) && eov, ERR_NONE);
        end
      end
    end else begin
      if (value_bytes != 16'hFFFF) value_bytes = value_bytes + 16'd1;
      if (dropping) begin
        if (eov) clear_value();
      end else if (value_bytes >= limit_now) begin
        flag_error(ERR_LONG, eov);
      end else if (!in_name) begin
        if (b == "&") begin
          if (eov) begin
            flag_error(ERR_CUT, eov);
          end else begin
            in_name  = 1'b1;
            name_buf = '0;
            name_cnt = '0;
          end
        end else begin
          emit(b, 1'b1, eov, ERR_NONE);
          if (eov) clear_value();
        end
      end else begin
        n = int'(name_cnt) + 1;
        for (int k = 0; k < NUM_ENT; k++) begin
          nm = ent_name(k[2:0]);
          ok = (n <= nm.len());
          for (int i = 0; ok && i < n - 1; i++) begin
            if (name_buf[8*i +: 8] != nm[i]) ok = 1'b0;
          end
          if (ok && b != nm[n-1]) ok = 1'b0;
          if (ok) begin
            prefix_ok = 1'b1;
            if (n == nm.len()) done_k = k;
          end
        end
        if (!prefix_ok) begin
          flag_error(ERR_UNKNOWN, eov);
        end else if (done_k >= 0) begin
          in_name  = 1'b0;
          name_buf = '0;
          name_cnt = '0;
          emit(ent_glyph(done_k[2:0]), 1'b1, eov, ERR_NONE);
          if (eov) clear_value();
        end else if (eov) begin
          flag_error(ERR_CUT, eov);
        end else begin
          name_buf[8*name_cnt +: 8] = b;
          name_cnt = name_cnt + 3'd1;
        end
      end
    end
  endtask

  // input side: present the head of pending_items, random gap after each beat
  always @(negedge clk) begin
    logic push_nxt;
    push_nxt = 1'b0;
    if (in_taken) begin
      in_taken = 1'b0;
      void'(pending_items.pop_front());
      in_wait = $urandom_range(0, in_gap_max);
    end
    if (rst_n) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (pending_items.size() != 0) begin
        push_nxt = 1'b1;
        in_data <= pending_items[0];
      end
    end
    push <= push_nxt;
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      predict_codec_beat(in_data);
      in_taken = 1'b1;
      beats_in++;
    end
  end

  // result side: random stall after each beat, plus a long hold on request
  always @(negedge clk) begin
    logic pop_nxt;
    pop_nxt = 1'b0;
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait = $urandom_range(0, out_gap_max);
    end
    if (out_hold_req) begin
      out_hold_req = 1'b0;
      out_hold_left = HOLD_CYCLES;
    end
    if (rst_n) begin
      if (out_hold_left > 0) begin
        out_hold_left--;
      end else if (out_wait > 0) begin
        out_wait--;
      end else begin
        pop_nxt = 1'b1;
      end
    end
    pop <= pop_nxt;
  end

  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && pop && !empty) begin
      out_taken = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: byte %02h error %0d",
               out_data.out_byte, out_data.error);
        mismatches++;
      end else begin
        exp = expected_results.pop_front();
        results_checked++;
        if (exp.error != ERR_NONE) error_results++;
        if (out_data.out_byte !== exp.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp.out_byte, out_data.out_byte);
          mismatches++;
        end
        if (out_data.last_of_run !== exp.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", exp.last_of_run, out_data.last_of_run);
          mismatches++;
        end
        if (out_data.value_done !== exp.value_done) begin
          $error("value_done: expected %0b, got %0b", exp.value_done, out_data.value_done);
          mismatches++;
        end
        if (out_data.error !== exp.error) begin
          $error("error: expected %0d, got %0d", exp.error, out_data.error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no beat accepted for %0d cycles", STALL_LIMIT);
        $display("xml_entity_codec verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t beat(input logic f, input logic [7:0] b, input logic e);
    in_item_t it;
    it.func         = f;
    it.data_byte    = b;
    it.end_of_value = e;
    return it;
  endfunction

  task automatic add_beat(input in_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_text(input logic f, input string s, input bit eov_last);
    for (int i = 0; i < s.len(); i++) begin
      add_beat(beat(f, s[i], eov_last && i == s.len() - 1));
    end
  endtask

  // one value: plain bytes, whole entities, broken entities, escaped bytes, noise
  task automatic add_random_value(input int parts);
    in_item_t   v[$];
    in_item_t   it;
    string      nm;
    int         pick;
    int         keep;
    logic [2:0] k;
    for (int p = 0; p < parts; p++) begin
      pick = $urandom_range(0, 99);
      k = 3'($urandom_range(0, NUM_ENT - 1));
      nm = ent_name(k);
      if (pick < 35) begin
        v.push_back(beat(FUNC_DECODE, 8'($urandom_range(0, 255)), 1'b0));
      end else if (pick < 60) begin
        v.push_back(beat(FUNC_DECODE, "&", 1'b0));
        for (int i = 0; i < nm.len(); i++) v.push_back(beat(FUNC_DECODE, nm[i], 1'b0));
      end else if (pick < 70) begin
        keep = $urandom_range(0, nm.len() - 1);
        v.push_back(beat(FUNC_DECODE, "&", 1'b0));
        for (int i = 0; i < keep; i++) v.push_back(beat(FUNC_DECODE, nm[i], 1'b0));
        if ($urandom_range(0, 1)) begin
          v.push_back(beat(FUNC_DECODE, 8'($urandom_range(0, 255)), 1'b0));
        end
      end else if (pick < 92) begin
        v.push_back(beat(FUNC_ENCODE,
                         $urandom_range(0, 1) ? ent_glyph(k) : 8'($urandom_range(0, 255)),
                         1'b0));
      end else begin
        v.push_back(beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1))));
      end
    end
    it = v.pop_back();
    it.end_of_value = 1'b1;
    v.push_back(it);
    foreach (v[i]) add_beat(v[i]);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || push || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of value_limit, then read it back
  task automatic set_value_limit(input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VALUE_LIMIT;
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_now = v;
    limit_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, limit_now}) begin
      $error("prdata: expected %08h, got %08h", {16'h0000, limit_now}, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int goal;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: escapes, decode across an encode beat, unknown, cut off, drop
    add_beat(beat(FUNC_ENCODE, 8'h00, 1'b0));
    add_text(FUNC_ENCODE, "<>&'\"", 1'b0);
    add_beat(beat(FUNC_ENCODE, 8'hFF, 1'b1));
    add_text(FUNC_DECODE, "&l", 1'b0);
    add_beat(beat(FUNC_ENCODE, "Q", 1'b0));
    add_text(FUNC_DECODE, "t;", 1'b0);
    add_beat(beat(FUNC_DECODE, 8'hFF, 1'b0));
    add_text(FUNC_DECODE, "&x", 1'b0);
    add_text(FUNC_DECODE, "ab", 1'b1);
    add_text(FUNC_DECODE, "&am", 1'b1);
    add_text(FUNC_DECODE, "&", 1'b1);
    wait_drained();

    // smallest limit: every decode byte is too long
    set_value_limit(16'd1);
    add_beat(beat(FUNC_DECODE, "a", 1'b0));
    add_beat(beat(FUNC_DECODE, "b", 1'b1));
    add_beat(beat(FUNC_ENCODE, "<", 1'b1));
    add_beat(beat(FUNC_DECODE, "c", 1'b1));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_value_limit(16'hFFFF);
          in_gap_max = 13;
          out_gap_max = 13;
        end
        1: begin
          set_value_limit(16'd8);
          in_gap_max = 0;
          out_gap_max = 13;
          // receiver holds off while escapes keep coming: queue fills, full rises
          out_hold_req = 1'b1;
          for (int i = 0; i < 30; i++) begin
            add_beat(beat(FUNC_ENCODE,
                          ent_glyph(3'($urandom_range(0, NUM_ENT - 1))),
                          i == 29));
          end
        end
        2: begin
          set_value_limit(16'($urandom_range(2, 40)));
          in_gap_max = 0;
          out_gap_max = 0;
        end
        default: begin
          set_value_limit(LIMIT_RESET);
          in_gap_max = 13;
          out_gap_max = 0;
        end
      endcase
      goal = items_queued + 80;
      while (items_queued < goal) add_random_value($urandom_range(1, 6));
      wait_drained();
    end

    $display("%0d input beats, %0d result beats checked (%0d error results)",
             beats_in, results_checked, error_results);
    $display("%0d value_limit settings, stalls on both sides, one long receiver hold",
             limit_writes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("xml_entity_codec verification clean");
    end else begin
      $display("xml_entity_codec verification failed");
    end
    $finish;
  end

endmodule
